FILE: rtl/wuf_pkg.sv
// shared types, constants and command codes of the weighted union-find engine
// no dependencies; imported by every module of the block except wuf_ram
`default_nettype none

package wuf_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned OpW      = 2;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t NodeCountReset = cnt_t'(MaxNodes);

  typedef enum logic [OpW-1:0] {
    OP_UNION  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REINIT = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [OpW-1:0] op;
    idx_t           node_a;
    idx_t           node_b;
  } req_t;

  typedef struct packed {
    idx_t root_a;
    idx_t root_b;
    logic were_connected;
    logic merged;
    cnt_t component_count;
    logic bad_node;
  } rsp_t;

  // parent memory read address source
  typedef enum logic [1:0] {
    PRD_A     = 2'd0,
    PRD_B     = 2'd1,
    PRD_CLIMB = 2'd2
  } prd_sel_e;

  // size memory read address source
  typedef enum logic {
    SRD_RA = 1'b0,
    SRD_RB = 1'b1
  } srd_sel_e;

  // kind of result to register
  typedef enum logic [2:0] {
    FIN_NONE  = 3'd0,
    FIN_BAD   = 3'd1,
    FIN_INIT  = 3'd2,
    FIN_QUERY = 3'd3,
    FIN_MERGE = 3'd4
  } fin_e;

  typedef struct packed {
    logic     accept;
    logic     clear;
    prd_sel_e prd_sel;
    logic     r_load;
    logic     set_ra;
    logic     set_rb;
    srd_sel_e srd_sel;
    logic     latch_sa;
    logic     link;
    fin_e     fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reinit;
    logic is_union;
    logic bad;
    logic at_root;
    logic connected;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/wuf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module wuf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/wuf_ctrl.sv
// sequencing state machine of the union-find engine
// depends on wuf_pkg; drives the datapath through ctrl_cmd_t
`default_nettype none

module wuf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  wuf_pkg::dp_stat_t stat_i,
  output wuf_pkg::ctrl_cmd_t cmd_o
);
  import wuf_pkg::*;

  typedef enum logic [10:0] {
    ST_INIT     = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_DISPATCH = 11'b000_0000_0100,
    ST_HOP_A    = 11'b000_0000_1000,
    ST_CHK_A    = 11'b000_0001_0000,
    ST_HOP_B    = 11'b000_0010_0000,
    ST_CHK_B    = 11'b000_0100_0000,
    ST_RESOLVE  = 11'b000_1000_0000,
    ST_SIZE_A   = 11'b001_0000_0000,
    ST_SIZE_B   = 11'b010_0000_0000,
    ST_CLEAR    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat_i.reinit) begin
          state_d = ST_CLEAR;
        end else if (stat_i.bad) begin
          cmd_o.fin = FIN_BAD;
          state_d   = ST_IDLE;
        end else begin
          cmd_o.prd_sel = PRD_A;
          cmd_o.r_load  = 1'b1;
          state_d       = ST_HOP_A;
        end
      end
      ST_HOP_A: begin
        cmd_o.prd_sel = PRD_CLIMB;
        state_d       = ST_CHK_A;
      end
      ST_CHK_A: begin
        if (stat_i.at_root) begin
          cmd_o.set_ra  = 1'b1;
          cmd_o.prd_sel = PRD_B;
          cmd_o.r_load  = 1'b1;
          state_d       = ST_HOP_B;
        end else begin
          cmd_o.prd_sel = PRD_CLIMB;
          cmd_o.r_load  = 1'b1;
          state_d       = ST_HOP_A;
        end
      end
      ST_HOP_B: begin
        cmd_o.prd_sel = PRD_CLIMB;
        state_d       = ST_CHK_B;
      end
      ST_CHK_B: begin
        if (stat_i.at_root) begin
          cmd_o.set_rb = 1'b1;
          state_d      = ST_RESOLVE;
        end else begin
          cmd_o.prd_sel = PRD_CLIMB;
          cmd_o.r_load  = 1'b1;
          state_d       = ST_HOP_B;
        end
      end
      ST_RESOLVE: begin
        if (stat_i.is_union && !stat_i.connected) begin
          cmd_o.srd_sel = SRD_RA;
          state_d       = ST_SIZE_A;
        end else begin
          cmd_o.fin = FIN_QUERY;
          state_d   = ST_IDLE;
        end
      end
      ST_SIZE_A: begin
        cmd_o.latch_sa = 1'b1;
        cmd_o.srd_sel  = SRD_RB;
        state_d        = ST_SIZE_B;
      end
      ST_SIZE_B: begin
        cmd_o.link = 1'b1;
        cmd_o.fin  = FIN_MERGE;
        state_d    = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          cmd_o.fin = FIN_INIT;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/wuf_dp.sv
// datapath of the union-find engine: parent and size memories, climb and result registers
// depends on wuf_pkg and wuf_ram; steered by wuf_ctrl through ctrl_cmd_t
`default_nettype none

module wuf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wuf_pkg::req_t      req_i,
  input  logic               cfg_valid_i,
  input  wuf_pkg::cnt_t      cfg_data_i,
  output logic               cfg_ready_o,
  input  wuf_pkg::ctrl_cmd_t cmd_i,
  output wuf_pkg::dp_stat_t  stat_o,
  output wuf_pkg::rsp_t      rsp_o,
  output logic               done_o
);
  import wuf_pkg::*;

  cnt_t            node_count_q;
  logic [OpW-1:0]  op_q;
  idx_t            a_q, b_q;
  logic            bad_q;
  idx_t            r_q, ra_q, rb_q;
  cnt_t            sa_q;
  idx_t            clr_idx_q;
  cnt_t            comp_q, comp_d;
  rsp_t            rsp_q, rsp_d;
  logic            done_q, done_d;

  idx_t            prnt_rdata, prnt_raddr, prnt_waddr, prnt_wdata;
  logic            prnt_we;
  cnt_t            size_rdata, size_wdata;
  idx_t            size_raddr, size_waddr;
  logic            size_we;

  logic            clr_last;
  logic            a_under;
  logic [CntW:0]   size_sum;
  cnt_t            size_link;
  cnt_t            init_count;
  logic            req_bad;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // index range check at accept
  assign req_bad = (cnt_t'(req_i.node_a) >= node_count_q)
                || (cnt_t'(req_i.node_b) >= node_count_q)
                || (cnt_t'(req_i.node_a) >= cnt_t'(MaxNodes))
                || (cnt_t'(req_i.node_b) >= cnt_t'(MaxNodes));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= req_i.op;
      a_q   <= req_i.node_a;
      b_q   <= req_i.node_b;
      bad_q <= req_bad;
    end
    if (cmd_i.r_load) begin
      r_q <= prnt_raddr;
    end
    if (cmd_i.set_ra) begin
      ra_q <= r_q;
    end
    if (cmd_i.set_rb) begin
      rb_q <= r_q;
    end
    if (cmd_i.latch_sa) begin
      sa_q <= size_rdata;
    end
  end

  // parent read address: a node to start from or the last link read back
  always_comb begin
    unique case (cmd_i.prd_sel)
      PRD_A:     prnt_raddr = a_q;
      PRD_B:     prnt_raddr = b_q;
      PRD_CLIMB: prnt_raddr = prnt_rdata;
      default:   prnt_raddr = prnt_rdata;
    endcase
  end

  assign size_raddr = (cmd_i.srd_sel == SRD_RB) ? rb_q : ra_q;

  // link: smaller tree under the larger, ties under root of node a
  assign a_under   = (sa_q < size_rdata);
  assign size_sum  = {1'b0, sa_q} + {1'b0, size_rdata};
  assign size_link = (size_sum > (CntW+1)'(MaxNodes)) ? cnt_t'(MaxNodes)
                                                      : size_sum[CntW-1:0];

  assign clr_last = (clr_idx_q == idx_t'(MaxNodes - 1));

  assign prnt_we    = cmd_i.clear || cmd_i.link;
  assign prnt_waddr = cmd_i.clear ? clr_idx_q : (a_under ? ra_q : rb_q);
  assign prnt_wdata = cmd_i.clear ? clr_idx_q : (a_under ? rb_q : ra_q);
  assign size_we    = cmd_i.clear || cmd_i.link;
  assign size_waddr = cmd_i.clear ? clr_idx_q : (a_under ? rb_q : ra_q);
  assign size_wdata = cmd_i.clear ? cnt_t'(1) : size_link;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_last ? '0 : clr_idx_q + idx_t'(1);
    end
  end

  wuf_ram #(
    .Width (IdxW),
    .Depth (MaxNodes)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (prnt_we),
    .waddr_i (prnt_waddr),
    .wdata_i (prnt_wdata),
    .raddr_i (prnt_raddr),
    .rdata_o (prnt_rdata)
  );

  wuf_ram #(
    .Width (CntW),
    .Depth (MaxNodes)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (size_raddr),
    .rdata_o (size_rdata)
  );

  assign init_count = (node_count_q > cnt_t'(MaxNodes)) ? cnt_t'(MaxNodes) : node_count_q;

  always_comb begin
    comp_d = comp_q;
    rsp_d  = rsp_q;
    done_d = 1'b0;
    unique case (cmd_i.fin)
      FIN_NONE: begin
      end
      FIN_BAD: begin
        rsp_d                 = '0;
        rsp_d.bad_node        = 1'b1;
        rsp_d.component_count = comp_q;
        done_d                = 1'b1;
      end
      FIN_INIT: begin
        comp_d                = init_count;
        rsp_d                 = '0;
        rsp_d.component_count = init_count;
        done_d                = 1'b1;
      end
      FIN_QUERY: begin
        rsp_d.root_a          = ra_q;
        rsp_d.root_b          = rb_q;
        rsp_d.were_connected  = (ra_q == rb_q);
        rsp_d.merged          = 1'b0;
        rsp_d.component_count = comp_q;
        rsp_d.bad_node        = 1'b0;
        done_d                = 1'b1;
      end
      FIN_MERGE: begin
        // count floors at zero
        comp_d                = (comp_q == '0) ? '0 : comp_q - cnt_t'(1);
        rsp_d.root_a          = ra_q;
        rsp_d.root_b          = rb_q;
        rsp_d.were_connected  = 1'b0;
        rsp_d.merged          = 1'b1;
        rsp_d.component_count = comp_d;
        rsp_d.bad_node        = 1'b0;
        done_d                = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= cnt_t'(MaxNodes);
      done_q <= 1'b0;
    end else begin
      comp_q <= comp_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  assign stat_o.reinit    = (op_q == OP_REINIT);
  assign stat_o.is_union  = (op_q == OP_UNION);
  assign stat_o.bad       = bad_q;
  assign stat_o.at_root   = (prnt_rdata == r_q);
  assign stat_o.connected = (ra_q == rb_q);
  assign stat_o.clr_last  = clr_last;

endmodule

`default_nettype wire

FILE: rtl/weighted_union_find.sv
// top level of the weighted quick-union disjoint-set engine
// depends on wuf_pkg, wuf_ctrl, wuf_dp (and through it wuf_ram)
`default_nettype none

// Disjoint-set engine over 1024 nodes with union, query and re-initialise
// commands. Pulse start with a command on req_i while busy is low; exactly
// one result beat follows on rsp_o, marked by done_o for one cycle, and it
// must be taken in that cycle. busy drops as the result is registered, so a
// new command can start in the same cycle the result beat is shown.
// After reset the block runs a clearing pass over both tables with busy high;
// the node_count register (cfg port) is writable throughout.
// Each root climb goes through the single read port of the parent memory,
// one double-hop at a time; at 1024 nodes a node lies at most 5 double-hops
// below its root. A re-initialise runs a full sweep of both tables.

module weighted_union_find (
  input  logic           clk_i,
  input  logic           rst_ni,
  // command channel
  input  logic           start,
  output logic           busy,
  input  wuf_pkg::req_t  req_i,
  // configuration write channel (node_count)
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  wuf_pkg::cnt_t  cfg_data_i,
  // result beats
  output logic           done_o,
  output wuf_pkg::rsp_t  rsp_o
);
  import wuf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: climbs, size reads, link, clearing sweep
  wuf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // tables, climb registers, component count and result register
  wuf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (rsp_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire

FILE: rtl/wuf_checker.sv
// port-level checks of weighted_union_find, attached by bind
// depends on wuf_pkg and the top level's port list
`default_nettype none

module wuf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input wuf_pkg::req_t req_i,
  input logic          cfg_valid_i,
  input logic          cfg_ready_o,
  input wuf_pkg::cnt_t cfg_data_i,
  input logic          done_o,
  input wuf_pkg::rsp_t rsp_o
);
  import wuf_pkg::*;

  // an accepted command keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted command");

  // a result beat closes a busy period and never repeats back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !$past(done_o)))
    else $error("result beat without a command in flight");

  // a merge joins two distinct roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.merged) |->
      (rsp_o.root_a != rsp_o.root_b && !rsp_o.were_connected && !rsp_o.bad_node))
    else $error("merge result inconsistent");

  // a rejected command reports no roots and no merge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.bad_node) |->
      (rsp_o.root_a == '0 && rsp_o.root_b == '0 && !rsp_o.merged
       && !rsp_o.were_connected))
    else $error("bad node result carries data");

endmodule

bind weighted_union_find wuf_checker u_wuf_checker (.*);

`default_nettype wire

FILE: bench/tb_weighted_union_find.sv
// self-checking testbench for the weighted union-find engine (weighted_union_find)
// depends on wuf_pkg and the rtl of the block; keeps its own model of both tables
`timescale 1ns / 1ps

module tb_weighted_union_find;
  import wuf_pkg::*;

  // generous ceiling on the length of a run
  localparam int unsigned CycleLimit = 1000000;
  // command beats per node_count setting in the random part
  localparam int unsigned ChunkItems = 45;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  cfg_valid_i;
  logic  cfg_ready_o;
  cnt_t  cfg_data_i;
  logic  done_o;
  rsp_t  rsp_o;

  weighted_union_find i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the forest: parent links, tree sizes, component count and
  // the node_count register as last written
  // ---------------------------------------------------------------------------
  idx_t parent_tbl [MaxNodes];
  cnt_t size_tbl [MaxNodes];
  cnt_t comp_count;
  cnt_t node_count_q;

  // result beats predicted but not yet seen on rsp_o, oldest first
  rsp_t pending_results [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  // chance in percent that the command side idles before a beat, drawn anew while it idles
  int unsigned idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_forest();
    for (int unsigned i = 0; i < MaxNodes; i++) begin
      parent_tbl[i] = idx_t'(i);
      size_tbl[i]   = cnt_t'(1);
    end
  endfunction

  // double-hop climb: jump to the grandparent until it maps back onto itself;
  // bounded so a corrupt table cannot hang the bench
  function automatic idx_t root_of(idx_t n);
    idx_t        r;
    idx_t        s;
    int unsigned steps;
    logic        found;
    r     = n;
    found = 1'b0;
    steps = 0;
    while (!found && steps < MaxNodes) begin
      s = parent_tbl[parent_tbl[r]];
      if (s == r) begin
        found = 1'b1;
      end else begin
        r = s;
      end
      steps++;
    end
    return r;
  endfunction

  // works out the result beat of one command and advances the shadow state
  function automatic rsp_t predict_union_find(req_t cmd);
    rsp_t           res;
    idx_t           ra;
    idx_t           rb;
    cnt_t           sa;
    cnt_t           sb;
    logic [CntW:0]  sum;
    res = '0;
    if (cmd.op == OP_REINIT) begin
      // the whole table is swept, whatever node_count says
      clear_forest();
      comp_count = (node_count_q > cnt_t'(MaxNodes)) ? cnt_t'(MaxNodes) : node_count_q;
    end else if (cmd.node_a >= node_count_q || cmd.node_b >= node_count_q) begin
      res.bad_node = 1'b1;
    end else begin
      ra = root_of(cmd.node_a);
      rb = root_of(cmd.node_b);
      res.root_a         = ra;
      res.root_b         = rb;
      res.were_connected = (ra == rb);
      // the spare code behaves as a query, so only a true union links
      if (cmd.op == OP_UNION && ra != rb) begin
        sa  = size_tbl[ra];
        sb  = size_tbl[rb];
        sum = {1'b0, sa} + {1'b0, sb};
        if (sum > (CntW+1)'(MaxNodes)) sum = (CntW+1)'(MaxNodes);
        // smaller tree goes under the larger, a tie under the first root
        if (sa < sb) begin
          parent_tbl[ra] = rb;
          size_tbl[rb]   = cnt_t'(sum);
        end else begin
          parent_tbl[rb] = ra;
          size_tbl[ra]   = cnt_t'(sum);
        end
        // count floor: stays at zero once node_count was raised past it
        if (comp_count != '0) comp_count = comp_count - 1'b1;
        res.merged = 1'b1;
      end
    end
    res.component_count = comp_count;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: every done_o beat is taken the cycle it shows and compared
  // field by field against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_o.root_a !== want.root_a)
          report_mismatch("root_a", rsp_o.root_a, want.root_a);
        if (rsp_o.root_b !== want.root_b)
          report_mismatch("root_b", rsp_o.root_b, want.root_b);
        if (rsp_o.were_connected !== want.were_connected)
          report_mismatch("were_connected", rsp_o.were_connected, want.were_connected);
        if (rsp_o.merged !== want.merged)
          report_mismatch("merged", rsp_o.merged, want.merged);
        if (rsp_o.component_count !== want.component_count)
          report_mismatch("component_count", rsp_o.component_count, want.component_count);
        if (rsp_o.bad_node !== want.bad_node)
          report_mismatch("bad_node", rsp_o.bad_node, want.bad_node);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // command side; every task is entered and left on a rising edge
  // ---------------------------------------------------------------------------

  // one command beat: optional idle cycles, then start held until busy is low
  // at an edge; start stays high on return so back-to-back beats need no gap
  task automatic send_cmd(op_e op, idx_t a, idx_t b);
    req_t cmd;
    cmd.op     = op;
    cmd.node_a = a;
    cmd.node_b = b;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(predict_union_find(cmd));
  endtask

  // hold off new commands until every pending result beat has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // node_count write; only called with the engine idle
  task automatic write_node_count(cnt_t value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    node_count_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic idx_t any_node(int unsigned lim);
    return (lim == 0) ? idx_t'($urandom_range(MaxNodes - 1)) : idx_t'($urandom_range(lim - 1));
  endfunction

  // an index at or above node_count where one exists
  function automatic idx_t bad_index(int unsigned lim);
    return (lim >= MaxNodes) ? idx_t'($urandom_range(MaxNodes - 1))
                             : idx_t'($urandom_range(MaxNodes - 1, lim));
  endfunction

  // pairwise merges of a block of 2^k nodes, doubling the span each round,
  // so the trees get as tall as weighting allows and the climbs get long
  task automatic send_merge_tree(input int unsigned lim, output int unsigned sent);
    int unsigned k;
    int unsigned span;
    int unsigned base;
    int unsigned step;
    int unsigned i;
    int unsigned x;
    int unsigned y;
    k    = (lim >= 32) ? $urandom_range(5, 3) : (lim >= 16) ? $urandom_range(4, 3) : 3;
    span = 1 << k;
    base = $urandom_range(lim - span);
    sent = 0;
    for (step = 1; step < span; step = step * 2) begin
      for (i = 0; i < span; i = i + 2 * step) begin
        x = base + i + $urandom_range(step - 1);
        y = base + i + step + $urandom_range(step - 1);
        if ($urandom_range(1)) send_cmd(OP_UNION, idx_t'(x), idx_t'(y));
        else send_cmd(OP_UNION, idx_t'(y), idx_t'(x));
        sent++;
      end
    end
  endtask

  // mostly in-range unions and queries, some spare codes, re-inits and
  // out-of-range indices as noise
  task automatic send_random_cmd(int unsigned lim);
    int unsigned pick;
    op_e         op;
    idx_t        a;
    idx_t        b;
    pick = $urandom_range(99);
    a    = any_node(lim);
    b    = any_node(lim);
    if (pick < 3) begin
      op = OP_REINIT;
      a  = idx_t'($urandom_range(MaxNodes - 1));
      b  = idx_t'($urandom_range(MaxNodes - 1));
    end else if (pick < 9) begin
      op = op_e'($urandom_range(3));
      if ($urandom_range(1)) a = bad_index(lim);
      else b = bad_index(lim);
    end else if (pick < 14) begin
      op = OP_SPARE;
    end else if (pick < 56) begin
      op = OP_UNION;
    end else begin
      op = OP_QUERY;
    end
    send_cmd(op, a, b);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // union, query, spare code and re-init at the reset node_count of 1024
  task automatic test_basic_ops();
    send_cmd(OP_UNION, 0, 1023);     // extremes, tie: 1023 under 0
    send_cmd(OP_QUERY, 1023, 0);
    send_cmd(OP_UNION, 1023, 0);     // already joined, no merge
    send_cmd(OP_SPARE, 1, 0);        // spare code acts as a query
    send_cmd(OP_UNION, 2, 1);
    send_cmd(OP_UNION, 1, 0);        // equal sizes, goes under root of node 1
    send_cmd(OP_QUERY, 1023, 1023);  // same node twice
    send_cmd(OP_UNION, 512, 511);
    send_cmd(OP_REINIT, 1023, 512);  // node fields ignored
    send_cmd(OP_QUERY, 1023, 1);
  endtask

  // rejected indices, node_count of one and of zero
  task automatic test_bad_nodes();
    drain_results();
    write_node_count(10);
    send_cmd(OP_REINIT, 0, 0);
    send_cmd(OP_UNION, 10, 3);
    send_cmd(OP_QUERY, 3, 10);
    send_cmd(OP_UNION, 1023, 1023);
    send_cmd(OP_UNION, 9, 0);
    drain_results();
    write_node_count(1);
    send_cmd(OP_REINIT, 0, 0);
    send_cmd(OP_UNION, 0, 0);
    send_cmd(OP_QUERY, 1, 0);
    drain_results();
    write_node_count(0);
    send_cmd(OP_QUERY, 0, 0);       // every index bad
    send_cmd(OP_REINIT, 0, 0);      // count becomes zero
    send_cmd(OP_UNION, 0, 0);
  endtask

  // raise node_count without a re-init so merges outrun the count
  task automatic test_count_floor();
    drain_results();
    write_node_count(3);
    send_cmd(OP_REINIT, 0, 0);
    drain_results();
    write_node_count(8);
    for (int unsigned i = 0; i < 7; i++) send_cmd(OP_UNION, idx_t'(i), idx_t'(i + 1));
  endtask

  // a walk through several node_count settings, most followed by a re-init
  task automatic test_random_traffic();
    cnt_t        settings [8];
    int unsigned lim;
    int unsigned sent;
    int unsigned n;
    settings = '{cnt_t'(16), cnt_t'(1024), cnt_t'(2), cnt_t'(64),
                 cnt_t'(1023), cnt_t'(2047), cnt_t'(256), cnt_t'(37)};
    foreach (settings[s]) begin
      drain_results();
      write_node_count(settings[s]);
      // now and then keep the old forest and count to exercise the floor
      if ($urandom_range(9) != 0) send_cmd(OP_REINIT, 0, 0);
      lim  = (node_count_q > cnt_t'(MaxNodes)) ? MaxNodes : node_count_q;
      sent = 0;
      while (sent < ChunkItems) begin
        if (lim >= 8 && $urandom_range(99) < 6) begin
          send_merge_tree(lim, n);
          sent += n;
        end else begin
          send_random_cmd(lim);
          sent++;
        end
        if ($urandom_range(99) == 0) drain_results();
      end
    end
  endtask

  initial begin
    start          = 1'b0;
    req_i          = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_pct       = 0;
    node_count_q   = NodeCountReset;
    comp_count     = cnt_t'(MaxNodes);
    clear_forest();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset keeps busy high
    do @(posedge clk_i); while (busy !== 1'b0);

    test_basic_ops();
    test_bad_nodes();
    test_count_floor();

    idle_pct = 6;
    test_random_traffic();
    idle_pct = 84;
    test_random_traffic();
    idle_pct = 0;
    test_random_traffic();

    drain_results();
    // catch stray beats after the last expected one
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
